// ----- rtl/core/mfwf_pkg.sv -----
// shared constants, register codes and arithmetic helpers of the wall follower
`default_nettype none

package mfwf_pkg;

  localparam int WINDOW_DEFAULT = 10;

  localparam int SAMPLE_W = 8;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 8;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_TARGET   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LIMIT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEADBAND = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_CRUISE   = 3'd5;

  localparam logic [7:0] TARGET_RESET   = 8'd10;
  localparam logic [6:0] BIAS_RESET     = 7'd10;
  localparam logic [7:0] GAIN_RESET     = 8'd51;
  localparam logic [6:0] LIMIT_RESET    = 7'd40;
  localparam logic [7:0] DEADBAND_RESET = 8'd5;
  localparam logic [6:0] CRUISE_RESET   = 7'd40;

  localparam logic signed [9:0] DRIVE_MAX = 10'sd100;
  localparam logic signed [9:0] DRIVE_MIN = -10'sd100;

  // signed q10.8 value divided by 256, rounded toward zero
  function automatic logic signed [9:0] div256_trunc(input logic signed [17:0] x);
    logic signed [9:0] q;
    q = x[17:8];
    if (x[17] && (x[7:0] != 8'd0)) begin
      q = q + 10'sd1;
    end
    return q;
  endfunction

  function automatic logic signed [7:0] sat100(input logic signed [9:0] v);
    logic signed [9:0] s;
    s = v;
    if (v > DRIVE_MAX) begin
      s = DRIVE_MAX;
    end else if (v < DRIVE_MIN) begin
      s = DRIVE_MIN;
    end
    return s[7:0];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/mfwf_if.sv -----
// valid/ready channels for distance samples and drive results
`default_nettype none

interface mfwf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] forward_sample;
  logic [7:0] side_sample;

  modport source (output valid, output forward_sample, output side_sample, input ready);
  modport sink (input valid, input forward_sample, input side_sample, output ready);
endinterface

interface mfwf_out_if;
  logic              valid;
  logic              ready;
  logic signed [7:0] right_drive;
  logic signed [7:0] left_drive;
  logic signed [8:0] forward_error;
  logic signed [7:0] steer_power;
  logic              in_deadband;

  modport source (output valid, output right_drive, output left_drive,
                  output forward_error, output steer_power, output in_deadband,
                  input ready);
  modport sink (input valid, input right_drive, input left_drive,
                input forward_error, input steer_power, input in_deadband,
                output ready);
endinterface

`default_nettype wire

// ----- rtl/core/median_filtered_wall_follower.sv -----
// wall follower: median filtered distances turned into proportional motor drives
//
// samples carries one forward and one side distance per transaction; drives
// carries one result per full window of WINDOW transactions, none otherwise.
// each accepted pair is inserted into two sorted windows by a compare-and-shift
// unit per window that moves one entry a cycle; the block takes no new pair
// until both units are done and it has returned to idle. the pair that
// completes the window then takes three more steps: the gain multiply, the
// clamp and deadband test, and the load of the output register.
// the window is then empty again and the next pair starts a new one.
// samples.ready is high whenever the sequencer is idle, also while a result
// waits in the output register; if the receiver stalls and a second result is
// due, the block holds in its final step until the first one is taken.
// the registers on the configuration port are written one per cycle with
// cfg_we and are meant to change only while the block is idle.
// reset empties the window, drops any pending result and restores the default
// target, bias, gain, limit, deadband and cruise values.
`default_nettype none

module median_filtered_wall_follower #(
  parameter int WINDOW = mfwf_pkg::WINDOW_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [mfwf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [mfwf_pkg::CFG_DATA_W-1:0] cfg_data,
  mfwf_in_if.sink                             samples,
  mfwf_out_if.source                          drives
);
  import mfwf_pkg::*;

  localparam int IW = $clog2(WINDOW);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_MUL,
    ST_CLAMP,
    ST_EMIT
  } state_t;

  state_t state;

  logic [7:0] target_distance;
  logic [6:0] forward_bias;
  logic [7:0] gain_q8;
  logic [6:0] power_limit;
  logic [7:0] deadband;
  logic [6:0] cruise_power;

  logic [IW-1:0] cnt;
  logic          last;
  logic          in_take;
  logic          f_busy;
  logic          s_busy;
  logic [7:0]    fmed;
  logic [7:0]    smed;

  logic signed [8:0]  err;
  logic signed [17:0] p;
  logic signed [17:0] p_cl;
  logic               dead;

  logic signed [8:0]  err_w;
  logic signed [8:0]  diff_w;
  logic signed [8:0]  gain_s;
  logic signed [17:0] prod;
  logic signed [17:0] diff_sh;
  logic signed [17:0] lim;
  logic signed [17:0] bias_sh;
  logic signed [17:0] r_sum;
  logic signed [17:0] l_sum;
  logic [8:0]         mag;
  logic signed [7:0]  sp_w;
  logic signed [7:0]  r_w;
  logic signed [7:0]  l_w;
  logic               emit_go;

  assign samples.ready = (state == ST_IDLE);
  assign in_take       = samples.valid && samples.ready;

  mfwf_sort_lane #(.WINDOW(WINDOW)) u_fwd (
    .clk    (clk),
    .rst    (rst),
    .start  (in_take),
    .slot   (cnt),
    .sample (samples.forward_sample),
    .busy   (f_busy),
    .median (fmed)
  );

  mfwf_sort_lane #(.WINDOW(WINDOW)) u_side (
    .clk    (clk),
    .rst    (rst),
    .start  (in_take),
    .slot   (cnt),
    .sample (samples.side_sample),
    .busy   (s_busy),
    .median (smed)
  );

  // steering arithmetic, one step per state
  assign err_w   = $signed({1'b0, fmed}) - $signed({1'b0, target_distance});
  assign diff_w  = $signed({1'b0, fmed}) - $signed({1'b0, smed});
  assign gain_s  = $signed({1'b0, gain_q8});
  assign prod    = err_w * gain_s;
  assign diff_sh = {diff_w[8], diff_w, 8'd0};

  assign lim = $signed({3'd0, power_limit, 8'd0});
  assign mag = err[8] ? 9'(-err) : 9'(err);

  assign bias_sh = $signed({3'd0, forward_bias, 8'd0});
  assign r_sum   = bias_sh - p_cl;
  assign l_sum   = bias_sh + p_cl;
  assign sp_w    = sat100(div256_trunc(p_cl));
  assign r_w     = dead ? sat100($signed({3'd0, cruise_power})) : sat100(div256_trunc(r_sum));
  assign l_w     = dead ? sat100($signed({3'd0, cruise_power})) : sat100(div256_trunc(l_sum));

  assign emit_go = (state == ST_EMIT) && (!drives.valid || drives.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      target_distance <= TARGET_RESET;
      forward_bias    <= BIAS_RESET;
      gain_q8         <= GAIN_RESET;
      power_limit     <= LIMIT_RESET;
      deadband        <= DEADBAND_RESET;
      cruise_power    <= CRUISE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET:   target_distance <= cfg_data;
        REG_BIAS:     forward_bias    <= cfg_data[6:0];
        REG_GAIN:     gain_q8         <= cfg_data;
        REG_LIMIT:    power_limit     <= cfg_data[6:0];
        REG_DEADBAND: deadband        <= cfg_data;
        REG_CRUISE:   cruise_power    <= cfg_data[6:0];
        default:      ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      cnt          <= '0;
      last         <= 1'b0;
      drives.valid <= 1'b0;
    end else begin
      // a new result replacing the taken one keeps valid high
      if (drives.valid && drives.ready && !emit_go) begin
        drives.valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (in_take) begin
            last  <= (cnt == IW'(WINDOW - 1));
            cnt   <= (cnt == IW'(WINDOW - 1)) ? '0 : cnt + 1'b1;
            state <= ST_SORT;
          end
        end
        ST_SORT: begin
          if (!f_busy && !s_busy) begin
            state <= last ? ST_MUL : ST_IDLE;
          end
        end
        ST_MUL: begin
          err   <= err_w;
          p     <= prod - diff_sh;
          state <= ST_CLAMP;
        end
        ST_CLAMP: begin
          if (p > lim) begin
            p_cl <= lim;
          end else if (p < -lim) begin
            p_cl <= -lim;
          end else begin
            p_cl <= p;
          end
          dead  <= (mag < {1'b0, deadband});
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit_go) begin
            drives.valid         <= 1'b1;
            drives.right_drive   <= r_w;
            drives.left_drive    <= l_w;
            drives.forward_error <= err;
            drives.steer_power   <= sp_w;
            drives.in_deadband   <= dead;
            state                <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_no_take_while_sorting: assert property (@(posedge clk) disable iff (rst)
    in_take |-> (!f_busy && !s_busy))
    else $error("sample taken while the insertion units are busy");

  a_window_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_MUL) |-> (cnt == '0))
    else $error("window count not cleared when the result is formed");

  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    emit_go |=> (drives.valid && (state == ST_IDLE)))
    else $error("result not loaded into the output register");

  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    drives.valid |-> (drives.right_drive <= 8'sd100 && drives.right_drive >= -8'sd100 &&
                      drives.left_drive <= 8'sd100 && drives.left_drive >= -8'sd100))
    else $error("drive outside the saturation range");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/mfwf_sort_lane.sv -----
// sorted sample window kept in order by a one-compare-per-cycle insertion unit
`default_nettype none

module mfwf_sort_lane #(
  parameter int WINDOW = mfwf_pkg::WINDOW_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  input  wire logic [$clog2(WINDOW)-1:0]    slot,
  input  wire logic [mfwf_pkg::SAMPLE_W-1:0] sample,
  output logic                              busy,
  output logic [mfwf_pkg::SAMPLE_W-1:0]     median
);
  import mfwf_pkg::*;

  localparam int IW = $clog2(WINDOW);

  logic [SAMPLE_W-1:0] entry [WINDOW];
  logic [IW-1:0]       hole;
  logic [SAMPLE_W-1:0] val;
  logic [IW-1:0]       rd_idx;
  logic [SAMPLE_W-1:0] rd;
  logic                shift;

  // the entry just below the hole is compared with the new sample
  assign rd_idx = (hole == '0) ? '0 : hole - 1'b1;
  assign rd     = entry[rd_idx];
  assign shift  = (hole != '0) && (rd > val);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && !shift) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      hole <= slot;
      val  <= sample;
    end else if (busy) begin
      if (shift) begin
        entry[hole] <= rd;
        hole        <= rd_idx;
      end else begin
        entry[hole] <= val;
      end
    end
  end

  assign median = entry[WINDOW / 2];

endmodule

`default_nettype wire
